// File: sv/gfa_pkg.sv
// Package for the greedy factory assignment block: beat types, queue entry,
// back-end state codes, configuration indexes and saturating add.
// No dependencies.
`timescale 1ns / 1ps

package gfa_pkg;

	// Fixed field widths
	localparam int FAC_W   = 3;
	localparam int TIME_W  = 16;
	localparam int COST_W  = 32;
	localparam int FCNT_W  = 4;
	localparam int CIDX_W  = 2;
	localparam int CDATA_W = 4;

	// Default factory count limit and decoupling queue depth
	localparam int MAX_FACTORIES_DEF = 8;
	localparam int QDEPTH            = 4;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_GLOBAL_MODE   = CIDX_W'(0);
	localparam logic [CIDX_W-1:0] CFG_FACTORY_COUNT = CIDX_W'(1);

	// Reset values of the configuration registers
	localparam logic              GLOBAL_MODE_RST   = 1'b1;
	localparam logic [FCNT_W-1:0] FACTORY_COUNT_RST = FCNT_W'(2);

	typedef struct packed {
		logic              restart;
		logic [FAC_W-1:0]  factory;
		logic [TIME_W-1:0] proc_time;
		logic              cand_last;
		logic              job_last;
	} in_item_t;

	typedef struct packed {
		logic [FAC_W-1:0]  chosen_factory;
		logic [COST_W-1:0] chosen_cost;
	} out_item_t;

	// One closed operation / restart / job end, front to back
	typedef struct packed {
		logic              restart;
		logic              add;
		logic [FAC_W-1:0]  factory;
		logic [TIME_W-1:0] op_min;
		logic              job_last;
	} qent_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic              global_mode;
		logic [FCNT_W-1:0] factory_count;
	} cfg_t;

	typedef enum logic [1:0] {
		BK_TAKE,
		BK_SCAN,
		BK_UPDATE
	} back_st_t;

	function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
		input logic [COST_W-1:0] b);
		logic [COST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
	endfunction

endpackage

// File: sv/gfa_front.sv
// Front end: accepts input beats, keeps the running operation minimum and
// pushes one queue entry per closed operation, restart or job end.
// Depends on gfa_pkg.
`timescale 1ns / 1ps

module gfa_front #(
	parameter int MAX_FACTORIES = gfa_pkg::MAX_FACTORIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  gfa_pkg::in_item_t in_data,
	input  gfa_pkg::qstat_t  qstat,
	output logic             push,
	output gfa_pkg::qent_t   push_data
);
	import gfa_pkg::*;

	logic [TIME_W:0] opmin_q;
	logic [TIME_W:0] m;
	logic            accept;
	logic            close;

	// Stall only on a full queue
	assign in_stall = qstat.full;
	assign accept   = in_valid && !in_stall;
	assign close    = in_data.cand_last || in_data.job_last;

	// Running minimum including this candidate
	assign m = ({1'b0, in_data.proc_time} < opmin_q) ? {1'b0, in_data.proc_time} : opmin_q;

	assign push = accept && (close || in_data.restart);

	always_comb begin
		push_data          = '0;
		push_data.restart  = in_data.restart;
		push_data.add      = close && (32'(in_data.factory) < MAX_FACTORIES);
		push_data.factory  = in_data.factory;
		push_data.op_min   = m[TIME_W-1:0];
		push_data.job_last = in_data.job_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opmin_q <= '1;
		end else if (accept) begin
			opmin_q <= close ? '1 : m;
		end
	end

	a_min_reopens: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && close) |=> (opmin_q == '1))
		else $error("operation minimum not reopened after close");

endmodule

// File: sv/gfa_queue.sv
// Short queue between front and back ends.
// Depends on gfa_pkg.
`timescale 1ns / 1ps

module gfa_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  gfa_pkg::qent_t  push_data,
	input  logic            pop,
	output gfa_pkg::qent_t  pop_data,
	output gfa_pkg::qstat_t qstat
);
	import gfa_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	qent_t           slot_q [QDEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;

	assign qstat.full  = (cnt_q == CW'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign pop_data    = slot_q[rd_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full && !pop))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && qstat.empty))
		else $error("pop from empty queue");

endmodule

// File: sv/gfa_back.sv
// Back end: per-factory job costs and loads, sequential argmin scan over the
// factories in use, and the result output register.
// Depends on gfa_pkg.
`timescale 1ns / 1ps

module gfa_back #(
	parameter int MAX_FACTORIES = gfa_pkg::MAX_FACTORIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gfa_pkg::cfg_t     cfg,
	input  gfa_pkg::qstat_t   qstat,
	input  gfa_pkg::qent_t    qent,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output gfa_pkg::out_item_t out_data
);
	import gfa_pkg::*;

	localparam int IW  = (MAX_FACTORIES > 1) ? $clog2(MAX_FACTORIES) : 1;
	localparam int NW0 = $clog2(MAX_FACTORIES + 1);
	localparam int NW  = (NW0 > FCNT_W) ? NW0 : FCNT_W;

	back_st_t          st_q, st_d;
	logic              scan_en;
	logic              upd_en;
	logic              last_k;

	logic [COST_W-1:0] job_cost_q [MAX_FACTORIES];
	logic [COST_W-1:0] load_q     [MAX_FACTORIES];
	logic [IW-1:0]     k_q;
	logic [IW-1:0]     best_q;
	logic [COST_W-1:0] best_cost_q;
	logic [COST_W-1:0] best_job_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic [NW-1:0]     fcnt;
	logic [NW-1:0]     n_use;
	logic [IW-1:0]     n_m1;
	logic [COST_W-1:0] jc_k;
	logic [COST_W-1:0] c_k;

	// Clamp the factory count to 1..MAX_FACTORIES
	always_comb begin
		fcnt = NW'(cfg.factory_count);
		if (fcnt == '0) begin
			n_use = NW'(1);
		end else if (fcnt > NW'(MAX_FACTORIES)) begin
			n_use = NW'(MAX_FACTORIES);
		end else begin
			n_use = fcnt;
		end
		n_m1 = IW'(n_use - NW'(1));
	end

	assign last_k = (k_q == n_m1);

	// Cost of the factory under scan
	assign jc_k = job_cost_q[k_q];
	assign c_k  = cfg.global_mode ? sat_add(jc_k, load_q[k_q]) : jc_k;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_TAKE;
		end else begin
			st_q <= st_d;
		end
	end

	// Next state and controls
	always_comb begin
		st_d    = st_q;
		pop     = 1'b0;
		scan_en = 1'b0;
		upd_en  = 1'b0;
		unique case (st_q)
			BK_TAKE: begin
				if (!qstat.empty) begin
					pop = 1'b1;
					if (qent.job_last) begin
						st_d = BK_SCAN;
					end
				end
			end
			BK_SCAN: begin
				scan_en = 1'b1;
				if (last_k) begin
					st_d = BK_UPDATE;
				end
			end
			BK_UPDATE: begin
				if (!out_valid_q || !out_stall) begin
					upd_en = 1'b1;
					st_d   = BK_TAKE;
				end
			end
			default: st_d = BK_TAKE;
		endcase
	end

	// Job cost lanes: add closed operation minimum, clear at job end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_FACTORIES; i++) begin
				job_cost_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < MAX_FACTORIES; i++) begin
				if (upd_en) begin
					job_cost_q[i] <= '0;
				end else if (pop && qent.add && (32'(qent.factory) == i)) begin
					job_cost_q[i] <= sat_add(job_cost_q[i],
						{{(COST_W-TIME_W){1'b0}}, qent.op_min});
				end
			end
		end
	end

	// Factory loads: cleared on restart, chosen factory grows in global mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_FACTORIES; i++) begin
				load_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < MAX_FACTORIES; i++) begin
				if (pop && qent.restart) begin
					load_q[i] <= '0;
				end else if (upd_en && cfg.global_mode && (32'(best_q) == i)) begin
					load_q[i] <= sat_add(load_q[i], best_job_q);
				end
			end
		end
	end

	// Argmin scan, lowest index wins ties
	always_ff @(posedge clk) begin
		if (pop && qent.job_last) begin
			k_q <= '0;
		end else if (scan_en) begin
			k_q <= k_q + 1'b1;
		end
		if (scan_en && ((k_q == '0) || (c_k < best_cost_q))) begin
			best_q      <= k_q;
			best_cost_q <= c_k;
			best_job_q  <= jc_k;
		end
	end

	// Result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_en) begin
			out_q.chosen_factory <= FAC_W'(best_q);
			out_q.chosen_cost    <= best_cost_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_SCAN) |-> (k_q <= n_m1))
		else $error("scan index beyond factories in use");

	a_update_shows: assert property (@(posedge clk) disable iff (!arst_n)
		upd_en |=> out_valid_q)
		else $error("result not presented after update");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != BK_TAKE) |-> !pop)
		else $error("queue popped during scan or update");

endmodule

// File: sv/greedy_factory_assignment_top.sv
// Greedy factory assignment: input channel (valid/stall), result channel
// (valid/stall) and configuration write port (valid/ready). One beat in,
// one result beat per job end. Candidate times and the running minimum enter
// the front end at one beat per cycle unless the queue is full; a 4-entry
// queue decouples it from the back end, which folds each closed operation
// into its factory's job cost. At job end the back end scans the n factories
// in use (n = clamped factory_count) one per cycle and then registers the
// result; other beats sustain one per cycle while the back end is not
// scanning or updating and the queue is not full.
// Reset clears the queue, the loads and job costs, the running minimum, and
// sets global_mode = 1 and factory_count = 2. While the result receiver
// stalls, the result register holds; the back end then waits in its update
// step and, once the queue fills, the input channel is stalled.
// Configuration is always ready and is meant to be written while idle.
// Depends on gfa_pkg, gfa_front, gfa_queue, gfa_back.
`timescale 1ns / 1ps

module greedy_factory_assignment_top #(
	parameter int MAX_FACTORIES = gfa_pkg::MAX_FACTORIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  gfa_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output gfa_pkg::out_item_t          out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [gfa_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [gfa_pkg::CDATA_W-1:0] cfg_data
);
	import gfa_pkg::*;

	cfg_t   cfg_q;
	qstat_t qstat;
	qent_t  push_data;
	qent_t  pop_data;
	logic   push;
	logic   pop;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.global_mode   <= GLOBAL_MODE_RST;
			cfg_q.factory_count <= FACTORY_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_GLOBAL_MODE) begin
				cfg_q.global_mode <= cfg_data[0];
			end else if (cfg_index == CFG_FACTORY_COUNT) begin
				cfg_q.factory_count <= cfg_data[FCNT_W-1:0];
			end
		end
	end

	gfa_front #(
		.MAX_FACTORIES(MAX_FACTORIES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	gfa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	gfa_back #(
		.MAX_FACTORIES(MAX_FACTORIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.qstat     (qstat),
		.qent      (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
